[hdl/assert_macros.svh]
// Assertion helpers: same-cycle and next-cycle implication, reset masked
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PMCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define PMCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pmct_pkg.sv]
package pmct_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_W          = 13;
  localparam int WIDTH_RST      = 1920;
  localparam int HEIGHT_RST     = 1080;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic EV_MOTION = 1'b0;
  localparam logic EV_BUTTON = 1'b1;

  localparam logic BTN_LEFT  = 1'b0;
  localparam logic BTN_RIGHT = 1'b1;

  localparam int STATUS_LEFT  = 0;
  localparam int STATUS_RIGHT = 1;
  localparam int STATUS_XSIGN = 4;
  localparam int STATUS_YSIGN = 5;

  typedef struct packed {
    logic left_chg;
    logic right_chg;
    logic left;
    logic right;
  } btn_t;

endpackage

[hdl/ps2_mouse_cursor_tracker.sv]
// PS/2 mouse cursor tracker.
// Input channel (in_valid_i/in_ready_o) takes one three-byte packet per item:
// status, x movement and y movement. Output channel (out_valid_o/out_ready_i)
// gives a motion result with the clamped cursor, then one button result for
// each change of the left and then the right button; last_of_run marks the
// final result of a packet. A packet gives one to three results.
// The cursor moves when the packet is taken; its results are registered in a
// holding slot and then an emitting slot. If the emitting slot is busy, the
// first result appears in the cycle after the last result of the packet ahead
// is taken. The two slots sit between the channels, so a new packet is taken
// while results still wait. Throughput is one result per cycle while
// out_ready_i is high; a packet holds the single output register for as many
// results as it gives.
// Reset centres the cursor on the default 1920 x 1080 screen and clears
// both button levels. Writing a screen size (cfg_we_i, index 0 width,
// index 1 height) recentres the cursor and keeps the button levels.
// A stalled receiver holds the current result; the holding slot fills and
// in_ready_o drops until the emitting slot drains.
module ps2_mouse_cursor_tracker import pmct_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            status_byte_i,
  input  logic [7:0]            x_move_byte_i,
  input  logic [7:0]            y_move_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  event_kind_o,
  output logic [COORD_BITS-1:0] pointer_x_o,
  output logic [COORD_BITS-1:0] pointer_y_o,
  output logic                  button_id_o,
  output logic                  pressed_o,
  output logic                  last_of_run_o
);

  `include "assert_macros.svh"

  localparam int SZW  = COORD_BITS + 1;
  localparam int MW   = (SZW > CFG_W) ? SZW : CFG_W;
  localparam int LIM  = 2 ** COORD_BITS;
  localparam int WR   = (WIDTH_RST > LIM) ? LIM : WIDTH_RST;
  localparam int HR   = (HEIGHT_RST > LIM) ? LIM : HEIGHT_RST;
  localparam int DW   = COORD_BITS + 2;

  typedef enum logic [1:0] {PH_MOTION, PH_LEFT, PH_RIGHT} phase_e;

  function automatic logic [SZW-1:0] sat_size(input logic [CFG_W-1:0] r);
    logic [MW-1:0] rx;
    rx = MW'(r);
    if (rx == '0) begin
      rx = MW'(1);
    end else if (rx > MW'(LIM)) begin
      rx = MW'(LIM);
    end
    return SZW'(rx);
  endfunction

  logic [SZW-1:0]        width_q, height_q;
  logic [SZW-1:0]        new_size;
  logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic                  left_q, right_q;

  logic                  a_valid_q;
  logic [COORD_BITS-1:0] a_x_q, a_y_q;
  btn_t                  a_btn_q;

  logic                  b_valid_q;
  logic [COORD_BITS-1:0] b_x_q, b_y_q;
  btn_t                  b_btn_q;
  phase_e                phase_q;

  logic signed [DW-1:0]  dx, dy_neg;
  logic [COORD_BITS-1:0] nx, ny;
  btn_t                  btn_d;
  logic                  in_fire, out_fire, is_last, b_load;

  assign dx     = DW'($signed({status_byte_i[STATUS_XSIGN], x_move_byte_i}));
  assign dy_neg = -DW'($signed({status_byte_i[STATUS_YSIGN], y_move_byte_i}));

  pmct_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .cur_i   (cur_x_q),
    .delta_i (dx),
    .size_i  (width_q),
    .next_o  (nx)
  );

  pmct_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .cur_i   (cur_y_q),
    .delta_i (dy_neg),
    .size_i  (height_q),
    .next_o  (ny)
  );

  always_comb begin
    btn_d.left      = status_byte_i[STATUS_LEFT];
    btn_d.right     = status_byte_i[STATUS_RIGHT];
    btn_d.left_chg  = status_byte_i[STATUS_LEFT] != left_q;
    btn_d.right_chg = status_byte_i[STATUS_RIGHT] != right_q;
  end

  assign new_size = sat_size(cfg_data_i);

  always_comb begin
    unique case (phase_q)
      PH_MOTION: is_last = !b_btn_q.left_chg && !b_btn_q.right_chg;
      PH_LEFT:   is_last = !b_btn_q.right_chg;
      default:   is_last = 1'b1;
    endcase
  end

  assign out_fire   = out_valid_o && out_ready_i;
  assign b_load     = a_valid_q && (!b_valid_q || (out_fire && is_last));
  assign in_ready_o = !a_valid_q || b_load;
  assign in_fire    = in_valid_i && in_ready_o;

  // cursor, button levels and screen size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SZW'(WR);
      height_q <= SZW'(HR);
      cur_x_q  <= COORD_BITS'(WR / 2);
      cur_y_q  <= COORD_BITS'(HR / 2);
      left_q   <= 1'b0;
      right_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_WIDTH) begin
        width_q <= new_size;
        cur_x_q <= new_size[SZW-1:1];
        cur_y_q <= height_q[SZW-1:1];
      end else begin
        height_q <= new_size;
        cur_x_q  <= width_q[SZW-1:1];
        cur_y_q  <= new_size[SZW-1:1];
      end
    end else if (in_fire) begin
      cur_x_q <= nx;
      cur_y_q <= ny;
      left_q  <= btn_d.left;
      right_q <= btn_d.right;
    end
  end

  // holding slot and emitting slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      phase_q   <= PH_MOTION;
    end else begin
      if (in_fire) begin
        a_valid_q <= 1'b1;
      end else if (b_load) begin
        a_valid_q <= 1'b0;
      end
      if (b_load) begin
        b_valid_q <= 1'b1;
        phase_q   <= PH_MOTION;
      end else if (out_fire) begin
        if (is_last) begin
          b_valid_q <= 1'b0;
          phase_q   <= PH_MOTION;
        end else if (phase_q == PH_MOTION && b_btn_q.left_chg) begin
          phase_q <= PH_LEFT;
        end else begin
          phase_q <= PH_RIGHT;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_x_q   <= nx;
      a_y_q   <= ny;
      a_btn_q <= btn_d;
    end
    if (b_load) begin
      b_x_q   <= a_x_q;
      b_y_q   <= a_y_q;
      b_btn_q <= a_btn_q;
    end
  end

  assign out_valid_o   = b_valid_q;
  assign pointer_x_o   = b_x_q;
  assign pointer_y_o   = b_y_q;
  assign last_of_run_o = is_last;

  always_comb begin
    unique case (phase_q)
      PH_LEFT: begin
        event_kind_o = EV_BUTTON;
        button_id_o  = BTN_LEFT;
        pressed_o    = b_btn_q.left;
      end
      PH_RIGHT: begin
        event_kind_o = EV_BUTTON;
        button_id_o  = BTN_RIGHT;
        pressed_o    = b_btn_q.right;
      end
      default: begin
        event_kind_o = EV_MOTION;
        button_id_o  = BTN_LEFT;
        pressed_o    = 1'b0;
      end
    endcase
  end

  `PMCT_ASSERT_NOW(a_left_phase_chg, b_valid_q && phase_q == PH_LEFT, b_btn_q.left_chg,
    "left button result without a left change")
  `PMCT_ASSERT_NOW(a_right_phase_chg, b_valid_q && phase_q == PH_RIGHT, b_btn_q.right_chg,
    "right button result without a right change")
  `PMCT_ASSERT_NEXT(a_last_restarts, out_fire && is_last, phase_q == PH_MOTION,
    "packet after a final result does not open with motion")
  `PMCT_ASSERT_NEXT(a_in_holds, in_fire, a_valid_q || b_valid_q,
    "accepted packet lost")

endmodule

[hdl/pmct_axis.sv]
module pmct_axis #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        cur_i,
  input  logic signed [COORD_BITS+1:0] delta_i,
  input  logic [COORD_BITS:0]          size_i,
  output logic [COORD_BITS-1:0]        next_o
);

  logic signed [COORD_BITS+1:0] sum;

  assign sum = $signed({2'b00, cur_i}) + delta_i;

  always_comb begin
    if (sum < 0) begin
      next_o = '0;
    end else if ($unsigned(sum) >= {1'b0, size_i}) begin
      next_o = COORD_BITS'(size_i - 1'b1);
    end else begin
      next_o = sum[COORD_BITS-1:0];
    end
  end

endmodule

[tb/sv/pointer_event_checker.sv]
`timescale 1ns / 1ps
module pointer_event_checker import pmct_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [7:0]                status_byte_i,
  input  logic [7:0]                x_move_byte_i,
  input  logic [7:0]                y_move_byte_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      event_kind_i,
  input  logic [COORD_BITS_DEF-1:0] pointer_x_i,
  input  logic [COORD_BITS_DEF-1:0] pointer_y_i,
  input  logic                      button_id_i,
  input  logic                      pressed_i,
  input  logic                      last_of_run_i,
  output int                        mismatch_count_o,
  output int                        pending_o
);

  localparam int COORD_W      = COORD_BITS_DEF;
  localparam int SCREEN_MAX   = 1 << COORD_W;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               button;
    logic               level;
    logic               last;
  } pointer_event_t;

  pointer_event_t   pending_events[$];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int               cursor_x;
  int               cursor_y;
  logic             left_down;
  logic             right_down;
  int               mismatch_total = 0;

  function automatic int effective_size(logic [CFG_W-1:0] reg_value);
    int size;
    size = int'(reg_value);
    if (size < 1) size = 1;
    if (size > SCREEN_MAX) size = SCREEN_MAX;
    return size;
  endfunction

  function automatic int clamp_coord(int v, int size);
    if (v < 0) v = 0;
    if (v >= size) v = size - 1;
    return v;
  endfunction

  function automatic pointer_event_t make_event(logic kind, logic button, logic level,
                                                logic last);
    pointer_event_t ev;
    ev.kind   = kind;
    ev.x      = cursor_x[COORD_W-1:0];
    ev.y      = cursor_y[COORD_W-1:0];
    ev.button = button;
    ev.level  = level;
    ev.last   = last;
    return ev;
  endfunction

  task automatic recentre();
    cursor_x = effective_size(width_reg) / 2;
    cursor_y = effective_size(height_reg) / 2;
  endtask

  task automatic report_mismatch(string what);
    mismatch_total++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic apply_packet(logic [7:0] st, logic [7:0] xb, logic [7:0] yb);
    int   dx;
    int   dy;
    logic left;
    logic right;
    logic left_chg;
    logic right_chg;
    dx = int'(xb);
    dy = int'(yb);
    if (st[STATUS_XSIGN]) dx -= 256;
    if (st[STATUS_YSIGN]) dy -= 256;
    cursor_x  = clamp_coord(cursor_x + dx, effective_size(width_reg));
    cursor_y  = clamp_coord(cursor_y - dy, effective_size(height_reg));
    left      = st[STATUS_LEFT];
    right     = st[STATUS_RIGHT];
    left_chg  = left != left_down;
    right_chg = right != right_down;
    pending_events.push_back(make_event(EV_MOTION, 1'b0, 1'b0, !(left_chg || right_chg)));
    if (left_chg) begin
      pending_events.push_back(make_event(EV_BUTTON, BTN_LEFT, left, !right_chg));
      left_down = left;
    end
    if (right_chg) begin
      pending_events.push_back(make_event(EV_BUTTON, BTN_RIGHT, right, 1'b1));
      right_down = right;
    end
  endtask

  task automatic check_result();
    pointer_event_t got;
    pointer_event_t exp;
    got.kind   = event_kind_i;
    got.x      = pointer_x_i;
    got.y      = pointer_y_i;
    got.button = button_id_i;
    got.level  = pressed_i;
    got.last   = last_of_run_i;
    if (pending_events.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d x %0d y %0d btn %0d lvl %0d last %0d",
                                got.kind, got.x, got.y, got.button, got.level, got.last));
    end else begin
      exp = pending_events.pop_front();
      if (got.kind !== exp.kind || got.x !== exp.x || got.y !== exp.y ||
          got.button !== exp.button || got.level !== exp.level || got.last !== exp.last) begin
        report_mismatch($sformatf(
          "got kind %0d x %0d y %0d btn %0d lvl %0d last %0d, exp %0d %0d %0d %0d %0d %0d",
          got.kind, got.x, got.y, got.button, got.level, got.last,
          exp.kind, exp.x, exp.y, exp.button, exp.level, exp.last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_events.delete();
      width_reg  = CFG_W'(WIDTH_RST);
      height_reg = CFG_W'(HEIGHT_RST);
      recentre();
      left_down  = 1'b0;
      right_down = 1'b0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (cfg_we_i) begin
        if (cfg_index_i == REG_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
        recentre();
      end
      if (in_valid_i && in_ready_i) apply_packet(status_byte_i, x_move_byte_i, y_move_byte_i);
    end
    mismatch_count_o <= mismatch_total;
    pending_o        <= pending_events.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top import pmct_pkg::*; ();

  localparam int CYCLE_LIMIT       = 200000;
  localparam int DRAIN_LIMIT       = 5000;
  localparam int RANDOM_PHASES     = 8;
  localparam int PACKETS_PER_PHASE = 46;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      pkt_valid;
  logic                      pkt_ready;
  logic [7:0]                status_byte;
  logic [7:0]                x_move_byte;
  logic [7:0]                y_move_byte;
  logic                      ev_valid;
  logic                      ev_ready;
  logic                      event_kind;
  logic [COORD_BITS_DEF-1:0] pointer_x;
  logic [COORD_BITS_DEF-1:0] pointer_y;
  logic                      button_id;
  logic                      pressed;
  logic                      last_of_run;

  int         mismatch_count;
  int         pending_count;
  int         cycle_count;
  int         in_idle_odds;
  int         out_idle_odds;
  logic [1:0] held_buttons;

  logic [CFG_W-1:0] phase_width  [RANDOM_PHASES] = '{0, 1, 4096, 4097, 2, 640, 0, 1920};
  logic [CFG_W-1:0] phase_height [RANDOM_PHASES] = '{8191, 4096, 1, 0, 3, 480, 0, 1080};

  ps2_mouse_cursor_tracker DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (pkt_valid),
    .in_ready_o    (pkt_ready),
    .status_byte_i (status_byte),
    .x_move_byte_i (x_move_byte),
    .y_move_byte_i (y_move_byte),
    .out_valid_o   (ev_valid),
    .out_ready_i   (ev_ready),
    .event_kind_o  (event_kind),
    .pointer_x_o   (pointer_x),
    .pointer_y_o   (pointer_y),
    .button_id_o   (button_id),
    .pressed_o     (pressed),
    .last_of_run_o (last_of_run)
  );

  pointer_event_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (pkt_valid),
    .in_ready_i       (pkt_ready),
    .status_byte_i    (status_byte),
    .x_move_byte_i    (x_move_byte),
    .y_move_byte_i    (y_move_byte),
    .out_valid_i      (ev_valid),
    .out_ready_i      (ev_ready),
    .event_kind_i     (event_kind),
    .pointer_x_i      (pointer_x),
    .pointer_y_i      (pointer_y),
    .button_id_i      (button_id),
    .pressed_i        (pressed),
    .last_of_run_i    (last_of_run),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Result side: random stall bursts
  initial begin
    int stall;
    ev_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_idle_odds != 0 && $urandom_range(1, out_idle_odds) == 1) begin
        ev_ready <= 1'b0;
        stall = $urandom_range(1, 13);
        repeat (stall - 1) @(negedge clk);
      end else begin
        ev_ready <= 1'b1;
      end
    end
  end

  task automatic send_packet(logic [7:0] st, logic [7:0] xb, logic [7:0] yb);
    int gap;
    if (in_idle_odds != 0 && $urandom_range(1, in_idle_odds) == 1) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      pkt_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pkt_valid   <= 1'b1;
    status_byte <= st;
    x_move_byte <= xb;
    y_move_byte <= yb;
    held_buttons = st[1:0];
    do @(posedge clk); while (!pkt_ready);
  endtask

  task automatic send_random_packet();
    logic [7:0] st;
    logic [7:0] xb;
    logic [7:0] yb;
    int         mode;
    st   = 8'($urandom_range(0, 255));
    xb   = 8'($urandom_range(0, 255));
    yb   = 8'($urandom_range(0, 255));
    mode = $urandom_range(0, 3);
    if ($urandom_range(0, 1) == 1) st[1:0] = held_buttons;
    if (mode == 2) begin
      xb = st[STATUS_XSIGN] ? 8'(256 - $urandom_range(1, 8)) : 8'($urandom_range(0, 8));
      yb = st[STATUS_YSIGN] ? 8'(256 - $urandom_range(1, 8)) : 8'($urandom_range(0, 8));
    end else if (mode == 3) begin
      xb = st[STATUS_XSIGN] ? 8'h00 : 8'hFF;
      yb = st[STATUS_YSIGN] ? 8'h00 : 8'hFF;
    end
    send_packet(st, xb, yb);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drop valid and wait for every expected result to drain
  task automatic settle();
    int waited;
    @(negedge clk);
    pkt_valid <= 1'b0;
    waited = 0;
    while (pending_count != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_WIDTH;
    cfg_data      = '0;
    pkt_valid     = 1'b0;
    status_byte   = '0;
    x_move_byte   = '0;
    y_move_byte   = '0;
    held_buttons  = '0;
    in_idle_odds  = 4;
    out_idle_odds = 3;
    phase_width[6]  = CFG_W'($urandom_range(1, 8191));
    phase_height[6] = CFG_W'($urandom_range(1, 8191));
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_packet(8'h00, 8'h00, 8'h00);
    send_packet(8'h01, 8'h7F, 8'h00);
    send_packet(8'h03, 8'h00, 8'h7F);
    send_packet(8'h00, 8'h80, 8'h80);
    send_packet(8'h10, 8'h80, 8'h00);
    send_packet(8'h30, 8'h00, 8'h00);
    send_packet(8'hCC, 8'hFF, 8'hFF);
    send_packet(8'hCF, 8'h01, 8'h01);
    send_packet(8'h02, 8'h00, 8'h00);
    send_packet(8'h00, 8'h00, 8'h00);
    // drive to the left and bottom edges, then the right and top edges
    repeat (5) send_packet(8'h30, 8'h00, 8'h00);
    repeat (8) send_packet(8'h00, 8'hFF, 8'hFF);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(REG_WIDTH, phase_width[p]);
      write_reg(REG_HEIGHT, phase_height[p]);
      in_idle_odds  = (p % 3 == 2) ? 0 : 4;
      out_idle_odds = (p % 3 == 1) ? 0 : 3;
      if (p == RANDOM_PHASES - 1) begin
        in_idle_odds  = 0;
        out_idle_odds = 0;
      end
      repeat (PACKETS_PER_PHASE) send_random_packet();
      settle();
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
